@@ design/lesf_pkg.sv @@
// Package for the largest empty square finder.
// Holds the size limits, field widths, register indexes and reset values.
// No dependencies.
package lesf_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int SIZE_W = 11;
  localparam int DIM_W  = 11;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_GRID_ROWS     = 2'd0,
    REG_GRID_COLS     = 2'd1,
    REG_EMPTY_CHAR    = 2'd2,
    REG_OBSTACLE_CHAR = 2'd3
  } reg_idx_e;

  localparam logic [DIM_W-1:0]  GRID_ROWS_RST     = DIM_W'(10);
  localparam logic [DIM_W-1:0]  GRID_COLS_RST     = DIM_W'(10);
  localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST    = CHAR_W'(111);
  localparam logic [CHAR_W-1:0] OBSTACLE_CHAR_RST = CHAR_W'(120);

  localparam logic [DIM_W-1:0] MAX_ROWS_DIM = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] MAX_COLS_DIM = DIM_W'(MAX_COLS);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ design/lesf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lesf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/largest_empty_square_finder.sv @@
// Throughput: one cell per cycle, but the last cell of a grid waits while a result
// is held. The line buffer RAM is read at the cell's acceptance and written back as
// the cell advances, with forwarding for one-column grids.
// Reset: control, counters and the best square clear at once; the line buffer
// has no clearing pass and is written by the first row of every grid.
module largest_empty_square_finder
  import lesf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CHAR_W-1:0]   cell_char_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SIZE_W-1:0]   best_size_o,
  output logic [ROW_W-1:0]    best_row_o,
  output logic [COL_W-1:0]    best_col_o,
  output logic                found_o
);

  logic [DIM_W-1:0]  grid_rows_q, grid_cols_q;
  logic [CHAR_W-1:0] empty_char_q, obstacle_char_q;
  logic [DIM_W-1:0]  rows_eff, cols_eff;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              in_acc;

  logic              s1_valid_q, s1_valid_d;
  logic [CHAR_W-1:0] s1_char_q;
  logic [COL_W-1:0]  s1_col_q;
  logic [ROW_W-1:0]  s1_row_q;
  logic              s1_adv, s1_last;

  logic              fwd_hit_q;
  logic [SIZE_W-1:0] fwd_data_q;
  logic [SIZE_W-1:0] ram_rdata;

  logic [SIZE_W-1:0] left_q, left_d, diag_q, diag_d;
  logic [SIZE_W-1:0] up, dg, lf, m, s;
  logic              is_free;
  logic [ROW_W-1:0]  tr;
  logic [COL_W-1:0]  tc;

  logic [SIZE_W-1:0] best_size_q, best_size_d, best_size_n;
  logic [ROW_W-1:0]  best_row_q, best_row_d, best_row_n;
  logic [COL_W-1:0]  best_col_q, best_col_d, best_col_n;
  logic              better;

  logic              out_valid_q, out_valid_d, out_load;
  logic [SIZE_W-1:0] out_size_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_GRID_ROWS:     prdata = DATA_W'(grid_rows_q);
      REG_GRID_COLS:     prdata = DATA_W'(grid_cols_q);
      REG_EMPTY_CHAR:    prdata = DATA_W'(empty_char_q);
      REG_OBSTACLE_CHAR: prdata = DATA_W'(obstacle_char_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q     <= GRID_ROWS_RST;
      grid_cols_q     <= GRID_COLS_RST;
      empty_char_q    <= EMPTY_CHAR_RST;
      obstacle_char_q <= OBSTACLE_CHAR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GRID_ROWS:     grid_rows_q     <= pwdata[DIM_W-1:0];
        REG_GRID_COLS:     grid_cols_q     <= pwdata[DIM_W-1:0];
        REG_EMPTY_CHAR:    empty_char_q    <= pwdata[CHAR_W-1:0];
        REG_OBSTACLE_CHAR: obstacle_char_q <= pwdata[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  assign rows_eff = clamp_dim(grid_rows_q, MAX_ROWS_DIM);
  assign cols_eff = clamp_dim(grid_cols_q, MAX_COLS_DIM);

  // front counters: position of the next request
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if ({1'b0, col_q} + DIM_W'(1) == cols_eff) begin
        col_d = '0;
        if ({1'b0, row_q} + DIM_W'(1) == rows_eff) begin
          row_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // line buffer
  lesf_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (s),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // size computation
  assign is_free = (s1_char_q == empty_char_q) && (s1_char_q != obstacle_char_q);
  assign up      = (s1_row_q != '0) ? (fwd_hit_q ? fwd_data_q : ram_rdata) : '0;
  assign dg      = (s1_row_q != '0 && s1_col_q != '0) ? diag_q : '0;
  assign lf      = (s1_col_q != '0) ? left_q : '0;

  always_comb begin
    m = (up < lf) ? up : lf;
    if (dg < m) begin
      m = dg;
    end
    s = is_free ? m + SIZE_W'(1) : '0;
  end

  assign tr = ROW_W'({1'b0, s1_row_q} + SIZE_W'(1) - s);
  assign tc = COL_W'({1'b0, s1_col_q} + SIZE_W'(1) - s);

  assign better = (s != '0) &&
                  ((s > best_size_q) ||
                   ((s == best_size_q) &&
                    ({1'b0, tr} + {1'b0, tc} < {1'b0, best_row_q} + {1'b0, best_col_q})));

  assign best_size_n = better ? s  : best_size_q;
  assign best_row_n  = better ? tr : best_row_q;
  assign best_col_n  = better ? tc : best_col_q;

  assign s1_last = ({1'b0, s1_col_q} + DIM_W'(1) == cols_eff) &&
                   ({1'b0, s1_row_q} + DIM_W'(1) == rows_eff);
  assign s1_adv  = s1_valid_q && (!s1_last || !out_valid_q || out_ready_i);
  assign out_load = s1_adv && s1_last;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    left_d      = left_q;
    diag_d      = diag_q;
    best_size_d = best_size_q;
    best_row_d  = best_row_q;
    best_col_d  = best_col_q;
    if (s1_adv) begin
      s1_valid_d  = 1'b0;
      left_d      = s;
      diag_d      = up;
      best_size_d = best_size_n;
      best_row_d  = best_row_n;
      best_col_d  = best_col_n;
      if (s1_last) begin
        best_size_d = '0;
        best_row_d  = '0;
        best_col_d  = '0;
      end
    end
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end
    out_valid_d = (out_valid_q && !out_ready_i) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
      out_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
    end else if (cfg_wr) begin
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
      out_valid_q <= out_valid_d;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_valid_d;
      left_q      <= left_d;
      diag_q      <= diag_d;
      best_size_q <= best_size_d;
      best_row_q  <= best_row_d;
      best_col_q  <= best_col_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        fwd_hit_q <= s1_adv && (s1_col_q == col_q);
      end
    end
  end

  // request payload, forwarded write data and output result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q  <= cell_char_i;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      fwd_data_q <= s;
    end
    if (out_load) begin
      out_size_q <= best_size_n;
      out_row_q  <= best_row_n;
      out_col_q  <= best_col_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign best_size_o = out_size_q;
  assign best_row_o  = out_row_q;
  assign best_col_o  = out_col_q;
  assign found_o     = (out_size_q != '0);

endmodule

@@ design/lesf_checker.sv @@
// Port-level checks for the largest empty square finder.
// Depends on lesf_pkg; bound to the top level at the end of this file.
module lesf_checker
  import lesf_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [SIZE_W-1:0] best_size_o,
  input logic [ROW_W-1:0]  best_row_o,
  input logic [COL_W-1:0]  best_col_o,
  input logic              found_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_size_o) &&
      $stable(best_row_o) && $stable(best_col_o))
    else $error("result changed while stalled");

  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> found_o == (best_size_o != '0))
    else $error("found disagrees with size");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> best_row_o == '0 && best_col_o == '0)
    else $error("corner not zero without a free cell");

  a_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, best_row_o} + best_size_o <= SIZE_W'(MAX_ROWS)) &&
      ({1'b0, best_col_o} + best_size_o <= SIZE_W'(MAX_COLS)))
    else $error("square exceeds grid limits");

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .best_size_o (best_size_o),
  .best_row_o  (best_row_o),
  .best_col_o  (best_col_o),
  .found_o     (found_o)
);

@@ dv/tb_top.sv @@
// Testbench for largest_empty_square_finder: streams grids of characters, predicts
// the largest free square of each grid and checks every result field by field.
// Depends on lesf_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;
  import lesf_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 300;
  localparam int RANDOM_CELLS = 1000;
  localparam int RANDOM_GRIDS = 40;

  typedef struct {
    logic [SIZE_W-1:0] size;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              found;
  } square_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CHAR_W-1:0] cell_char_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [SIZE_W-1:0] best_size_o;
  logic [ROW_W-1:0] best_row_o;
  logic [COL_W-1:0] best_col_o;
  logic found_o;

  // Shadow registers and scan state of the expected behavior
  logic [DIM_W-1:0]  cfg_rows  = GRID_ROWS_RST;
  logic [DIM_W-1:0]  cfg_cols  = GRID_COLS_RST;
  logic [CHAR_W-1:0] cfg_empty = EMPTY_CHAR_RST;
  logic [CHAR_W-1:0] cfg_obst  = OBSTACLE_CHAR_RST;
  logic [SIZE_W-1:0] line_sizes [MAX_COLS];
  logic [SIZE_W-1:0] left_sz = '0;
  logic [SIZE_W-1:0] diag_sz = '0;
  logic [SIZE_W-1:0] best_sz = '0;
  logic [ROW_W-1:0]  best_r = '0;
  logic [COL_W-1:0]  best_c = '0;
  int row_idx = 0;
  int col_idx = 0;

  square_t square_q[$];
  int mismatch_cnt = 0;
  int squares_checked = 0;
  int cells_sent = 0;
  int cycle_cnt = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int stall_cnt = 0;

  largest_empty_square_finder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cell_char_i (cell_char_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .best_size_o (best_size_o),
    .best_row_o  (best_row_o),
    .best_col_o  (best_col_o),
    .found_o     (found_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_cnt, square_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    if (quiet) begin
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 60) begin
      return 0;
    end else if (p < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int lim);
    if (v == '0) begin
      return 1;
    end else if (v > lim) begin
      return lim;
    end
    return v;
  endfunction

  function automatic int grid_cells();
    return eff_dim(cfg_rows, MAX_ROWS) * eff_dim(cfg_cols, MAX_COLS);
  endfunction

  function automatic void restart_scan();
    left_sz = '0;
    diag_sz = '0;
    row_idx = 0;
    col_idx = 0;
    best_sz = '0;
    best_r = '0;
    best_c = '0;
  endfunction

  function automatic void apply_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    case (idx)
      REG_GRID_ROWS: cfg_rows = value[DIM_W-1:0];
      REG_GRID_COLS: cfg_cols = value[DIM_W-1:0];
      REG_EMPTY_CHAR: cfg_empty = value[CHAR_W-1:0];
      REG_OBSTACLE_CHAR: cfg_obst = value[CHAR_W-1:0];
      default: ;
    endcase
    restart_scan();
  endfunction

  function automatic void predict_square(input logic [CHAR_W-1:0] ch);
    int up, dg, lf, s, tr, tc;
    up = (row_idx > 0) ? int'(line_sizes[col_idx]) : 0;
    dg = (row_idx > 0 && col_idx > 0) ? int'(diag_sz) : 0;
    lf = (col_idx > 0) ? int'(left_sz) : 0;
    s = 0;
    if (ch == cfg_empty && ch != cfg_obst) begin
      s = up;
      if (lf < s) s = lf;
      if (dg < s) s = dg;
      s++;
    end
    diag_sz = SIZE_W'(up);
    line_sizes[col_idx] = SIZE_W'(s);
    left_sz = SIZE_W'(s);
    if (s > 0) begin
      tr = row_idx + 1 - s;
      tc = col_idx + 1 - s;
      if (s > best_sz || (s == best_sz && tr + tc < int'(best_r) + int'(best_c))) begin
        best_sz = SIZE_W'(s);
        best_r = ROW_W'(tr);
        best_c = COL_W'(tc);
      end
    end
    if (col_idx + 1 < eff_dim(cfg_cols, MAX_COLS)) begin
      col_idx++;
    end else begin
      col_idx = 0;
      left_sz = '0;
      diag_sz = '0;
      if (row_idx + 1 < eff_dim(cfg_rows, MAX_ROWS)) begin
        row_idx++;
      end else begin
        square_q.push_back('{size: best_sz, row: best_r, col: best_c, found: best_sz != '0});
        restart_scan();
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("Mismatch on %s: expected %0d, got %0d", name, want, got);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    square_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (square_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("Unexpected result: size %0d row %0d col %0d found %0d",
                   best_size_o, best_row_o, best_col_o, found_o);
        end
      end else begin
        want = square_q.pop_front();
        squares_checked++;
        check_field("best_size", 16'(want.size), 16'(best_size_o));
        check_field("best_row", 16'(want.row), 16'(best_row_o));
        check_field("best_col", 16'(want.col), 16'(best_col_o));
        check_field("found", 16'(want.found), 16'(found_o));
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else if (stall_cnt > 0) begin
        out_ready_i <= 1'b0;
        stall_cnt--;
      end else begin
        out_ready_i <= 1'b1;
        stall_cnt = pick_gap();
      end
    end
  end

  task automatic send_cell(input logic [CHAR_W-1:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cell_char_i <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    predict_square(ch);
    cells_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_run(input int n, input logic [CHAR_W-1:0] ch);
    for (int i = 0; i < n; i++) begin
      send_cell(ch);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_cell(s[i]);
    end
  endtask

  task automatic send_grid(input int free_pct);
    int n, p;
    logic [CHAR_W-1:0] ch;
    n = grid_cells();
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < free_pct) begin
        ch = cfg_empty;
      end else if (p < free_pct + (100 - free_pct) * 3 / 4) begin
        ch = cfg_obst;
      end else begin
        ch = CHAR_W'($urandom_range(0, 255));
      end
      send_cell(ch);
    end
  endtask

  // Drop valid and hold until every pending result has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (square_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg(idx, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_dims(input int rows, input int cols);
    wait_idle();
    write_reg(REG_GRID_ROWS, DATA_W'(rows));
    write_reg(REG_GRID_COLS, DATA_W'(cols));
  endtask

  task automatic set_chars(input logic [CHAR_W-1:0] empty_ch, input logic [CHAR_W-1:0] obst_ch);
    wait_idle();
    write_reg(REG_EMPTY_CHAR, DATA_W'(empty_ch));
    write_reg(REG_OBSTACLE_CHAR, DATA_W'(obst_ch));
  endtask

  task automatic test_reset_config();
    send_grid(80);
    send_grid(95);
  endtask

  task automatic test_tie_break();
    set_dims(3, 6);
    send_text("xxxxooooxxooooxxxx");
    set_dims(3, 5);
    send_text("ooooooooooooooo");
  endtask

  task automatic test_no_free_cell();
    set_dims(2, 3);
    send_run(6, cfg_obst);
    send_text("ab#O X");
    set_chars("o", "o");
    send_run(6, "o");
  endtask

  task automatic test_char_extremes();
    set_chars(8'h00, 8'hff);
    send_cell(8'h00);
    send_cell(8'h00);
    send_cell(8'hff);
    send_cell(8'h00);
    send_cell(8'h00);
    send_cell(8'h00);
    set_chars(8'hff, 8'h00);
    send_cell(8'hff);
    send_cell(8'hff);
    send_cell(8'h7f);
    send_cell(8'hff);
    send_cell(8'hff);
    send_cell(8'h80);
  endtask

  task automatic test_degenerate_dims();
    set_chars(EMPTY_CHAR_RST, OBSTACLE_CHAR_RST);
    set_dims(0, 0);
    send_run(1, cfg_empty);
    send_run(1, cfg_obst);
    set_dims(1, 5);
    send_text("xooox");
    set_dims(5, 1);
    send_text("xoxoo");
  endtask

  task automatic test_max_dims();
    set_dims(1, 2047);
    send_run(1023, cfg_obst);
    send_run(1, cfg_empty);
    set_dims(1500, 1);
    send_run(1023, cfg_obst);
    send_run(1, cfg_empty);
  endtask

  task automatic test_backpressure();
    set_dims(1, 1);
    quiet = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_cell($urandom_range(0, 1) ? cfg_empty : CHAR_W'($urandom_range(0, 255)));
    end
    quiet = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_grids();
    int grids, start_cells, rows, cols;
    logic [CHAR_W-1:0] e_ch;
    grids = 0;
    start_cells = cells_sent;
    while (cells_sent - start_cells < RANDOM_CELLS && grids < RANDOM_GRIDS) begin
      quiet = (grids >= 10 && grids < 18);
      if ($urandom_range(0, 99) < 30) begin
        rows = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
        cols = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 64);
        set_dims(rows, cols);
      end
      if ($urandom_range(0, 99) < 15) begin
        e_ch = CHAR_W'($urandom_range(0, 255));
        set_chars(e_ch, ($urandom_range(0, 99) < 20) ? e_ch : CHAR_W'($urandom_range(0, 255)));
      end
      send_grid($urandom_range(50, 100));
      grids++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_config();
    test_tie_break();
    test_no_free_cell();
    test_char_extremes();
    test_degenerate_dims();
    test_max_dims();
    test_backpressure();
    test_random_grids();
    wait_idle();
    repeat (10) @(negedge clk_i);
    $display("Covered %0d cells and %0d grid results, from 1x1 grids to rows and columns of 1024,",
             cells_sent, squares_checked);
    $display("tie-breaking, grids without free cells and a long output stall with a full pipe.");
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ largest_empty_square_finder.f @@
design/lesf_pkg.sv
design/lesf_ram.sv
design/largest_empty_square_finder.sv
design/lesf_checker.sv
dv/tb_top.sv
